// File: hdl/sil_pkg.sv
// sil_pkg: shared types and codes for the sorted insert list.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package sil_pkg;

  localparam int DATA_W    = 32;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 6;
  localparam int DEPTH_DEF = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUMP_ELEM = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUMP_NONE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

  // largest value the count field can show
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     ins;      // insert ins_val this cycle
    logic                     rot;      // rotate occupied entries toward cell 0
    logic signed [DATA_W-1:0] ins_val;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/sil_cell.sv
// sil_cell: one storage cell of the sorted chain.
// Depends on sil_pkg (cell_ctrl_t, DATA_W).
`timescale 1ns / 1ps
`default_nettype none
module sil_cell (
  input  wire                              clk_i,
  input  wire sil_pkg::cell_ctrl_t         ctrl_i,
  input  wire                              occupied_i,  // index below count
  input  wire                              wrap_i,      // last occupied cell
  input  wire                              prev_lt_i,   // left cell keeps its value
  input  wire logic signed [sil_pkg::DATA_W-1:0] prev_val_i,
  input  wire logic signed [sil_pkg::DATA_W-1:0] next_val_i,
  input  wire logic signed [sil_pkg::DATA_W-1:0] head_val_i,
  output logic                             lt_o,
  output logic signed [sil_pkg::DATA_W-1:0] val_o
);
  import sil_pkg::*;

  logic signed [DATA_W-1:0] val_q, val_d;

  // stored value is smaller than the one being inserted
  assign lt_o  = occupied_i && (val_q < ctrl_i.ins_val);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (!lt_o) begin
        val_d = prev_lt_i ? ctrl_i.ins_val : prev_val_i;
      end
    end else if (ctrl_i.rot) begin
      val_d = wrap_i ? head_val_i : next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
`default_nettype wire

// File: hdl/sorted_insert_list.sv
// sorted_insert_list: bounded ascending list kept in a chain of compare cells.
// Insert, full drop, clear, empty dump: result register loads on transfer.
// Dump of N entries: N results, one per unstalled cycle, rotating past cell 0.
// Throughput: one insert or clear per unstalled cycle; input waits out a dump.
// Reset (rst_ni low, async) empties the list; cell contents are not cleared.
// Depends on sil_pkg and sil_cell.
`timescale 1ns / 1ps
`default_nettype none
module sorted_insert_list #(
  parameter int DEPTH = sil_pkg::DEPTH_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [sil_pkg::REQ_W-1:0]       req_type_i,
  input  wire logic signed [sil_pkg::DATA_W-1:0] value_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [sil_pkg::STATUS_W-1:0]         status_o,
  output logic signed [sil_pkg::DATA_W-1:0]    value_out_o,
  output logic [sil_pkg::COUNT_W-1:0]          count_o,
  output logic                                 last_o
);
  import sil_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  // control states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DMP  = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] dump_idx_q, dump_idx_d;

  // result register
  logic                     out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]      status_q, status_d;
  logic signed [DATA_W-1:0] value_out_q, value_out_d;
  logic [COUNT_W-1:0]       count_out_q, count_out_d;
  logic                     last_q, last_d;

  cell_ctrl_t ctrl;

  // chain wiring
  logic                     lt   [DEPTH];
  logic signed [DATA_W-1:0] vals [DEPTH];

  logic in_xfer, out_free, dump_last;
  logic [31:0] cnt_wide;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                     occ, wrap, p_lt;
      logic signed [DATA_W-1:0] p_val, n_val;
      assign occ  = (CntW'(gi) < count_q);
      assign wrap = (CntW'(gi) == (count_q - CntW'(1)));
      if (gi == 0) begin : g_first
        // cell 0 takes the new value whenever it does not keep its own
        assign p_lt  = 1'b1;
        assign p_val = '0;
      end else begin : g_mid
        assign p_lt  = lt[gi-1];
        assign p_val = vals[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_end
        assign n_val = vals[0];
      end else begin : g_nxt
        assign n_val = vals[gi+1];
      end
      sil_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occupied_i (occ),
        .wrap_i     (wrap),
        .prev_lt_i  (p_lt),
        .prev_val_i (p_val),
        .next_val_i (n_val),
        .head_val_i (vals[0]),
        .lt_o       (lt[gi]),
        .val_o      (vals[gi])
      );
    end
  endgenerate

  // result slot frees when empty or when its transfer completes this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign dump_last  = (dump_idx_q == (count_q - CntW'(1)));

  // count field saturates when DEPTH exceeds its range
  assign cnt_wide = 32'(count_d);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dump_idx_d  = dump_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    value_out_d = value_out_q;
    last_d      = last_q;
    ctrl.ins     = 1'b0;
    ctrl.rot     = 1'b0;
    ctrl.ins_val = value_i;

    if (state_q == ST_IDLE) begin
      if (in_xfer) begin
        case (req_type_i)
          REQ_INSERT: begin
            out_valid_d = 1'b1;
            value_out_d = '0;
            last_d      = 1'b1;
            if (count_q == CntW'(DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              ctrl.ins = 1'b1;
              count_d  = count_q + CntW'(1);
              status_d = ST_INSERTED;
            end
          end
          REQ_DUMP: begin
            if (count_q == '0) begin
              out_valid_d = 1'b1;
              status_d    = ST_DUMP_NONE;
              value_out_d = '0;
              last_d      = 1'b1;
            end else begin
              state_d    = ST_DMP;
              dump_idx_d = '0;
            end
          end
          REQ_CLEAR: begin
            count_d     = '0;
            out_valid_d = 1'b1;
            status_d    = ST_CLEARED;
            value_out_d = '0;
            last_d      = 1'b1;
          end
          default: begin
            // unused code: dropped without a result
          end
        endcase
      end
    end else if (out_free) begin
      // head cell goes out, chain rotates so order is restored once all have gone out
      ctrl.rot    = 1'b1;
      out_valid_d = 1'b1;
      status_d    = ST_DUMP_ELEM;
      value_out_d = vals[0];
      last_d      = dump_last;
      dump_idx_d  = dump_idx_q + CntW'(1);
      if (dump_last) begin
        state_d = ST_IDLE;
      end
    end

    count_out_d = count_out_q;
    if (out_valid_d && out_free) begin
      count_out_d = (cnt_wide > 32'(COUNT_MAX)) ? COUNT_MAX : cnt_wide[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    value_out_q <= value_out_d;
    count_out_q <= count_out_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_out_o = value_out_q;
  assign count_o     = count_out_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// File: hdl/sil_checker.sv
// sil_checker: port-level assertions for sorted_insert_list, with its bind.
// Depends on sil_pkg; attached to the top level by the bind below.
`timescale 1ns / 1ps
`default_nettype none
module sil_checker #(
  parameter int DEPTH = sil_pkg::DEPTH_DEF
) (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              out_valid_o,
  input wire                              out_stall_i,
  input wire logic [sil_pkg::STATUS_W-1:0] status_o,
  input wire logic signed [sil_pkg::DATA_W-1:0] value_out_o,
  input wire logic [sil_pkg::COUNT_W-1:0] count_o,
  input wire                              last_o
);
  import sil_pkg::*;

  localparam logic [COUNT_W-1:0] FullCnt =
    (DEPTH > 63) ? COUNT_MAX : COUNT_W'(DEPTH);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DUMP_ELEM) |-> last_o)
    else $error("single result without last");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DUMP_ELEM) |-> (value_out_o == '0))
    else $error("non-dump result carries a value");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (count_o == FullCnt))
    else $error("overflow with list not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_CLEARED) || (status_o == ST_DUMP_NONE))
    |-> (count_o == '0))
    else $error("clear or empty dump with nonzero count");

endmodule

bind sorted_insert_list sil_checker #(.DEPTH(DEPTH)) u_sil_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .value_out_o (value_out_o),
  .count_o     (count_o),
  .last_o      (last_o)
);
`default_nettype wire
